// ===== src/lfc_pkg.sv =====
// ============================================================================
// lfc_pkg
// Shared constants, types and codes of the looped frame crossfader: sizes of
// the frame store, fixed-point formats of the blend, controller states and
// the command and status groups between controller and datapath.
// ============================================================================
package lfc_pkg;

    // frame store geometry
    localparam int FRAME_DEPTH = 1024;
    localparam int SAMPLE_BITS = 16;
    localparam int ADDR_W      = $clog2(FRAME_DEPTH);
    localparam int CNT_W       = $clog2(FRAME_DEPTH + 1);
    localparam int MEM_AW      = ADDR_W + 1;
    localparam int MEM_DEPTH   = 2 * (1 << ADDR_W);

    // configuration registers
    localparam int CFG_IDX_W    = 1;
    localparam int LEN_W        = 11;
    localparam int LEN_RESET    = 256;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_EN  = 1'b1;

    // item operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // fade length limits, FADE_W holds L-1
    localparam int FADE_MIN = 2;
    localparam int FADE_MAX = 1024;
    localparam int FADE_W   = $clog2(FADE_MAX);
    localparam int KCMP_W   = (CNT_W > FADE_W) ? CNT_W : FADE_W;

    // blend numerator: |sum| <= 2^(SAMPLE_BITS-1) * (2^FADE_W - 1)
    localparam int NUM_W = SAMPLE_BITS + FADE_W;
    localparam int MAG_W = NUM_W - 1;

    // makeup gain in Q1.14, span is 2(sqrt2-1)
    localparam int GAIN_FRAC = 14;
    localparam int GAIN_ONE  = 16384;
    localparam int GAIN_SPAN = 13573;
    localparam int GAIN_W    = 15;
    localparam int GPROD_W   = MAG_W + GAIN_W;

    // shared divider: widest dividend is the gained numerator after rounding
    localparam int DIV_W   = GPROD_W + 1 - GAIN_FRAC;
    localparam int DCNT_W  = $clog2(DIV_W);
    localparam int SAT_MAX = (1 << (SAMPLE_BITS - 1)) - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_TICK,
        S_PLAY,
        S_FADE_OLD,
        S_FADE_NEW,
        S_GDIV_GO,
        S_GDIV_WAIT,
        S_GAIN_MUL,
        S_NDIV_GO,
        S_NDIV_WAIT,
        S_FADE_END,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_PLAY,
        MODE_FADE
    } tick_mode_t;

    typedef struct packed {
        logic accept;
        logic load_step;
        logic tick_setup;
        logic play_cap;
        logic fade_old;
        logic fade_new;
        logic gdiv_go;
        logic gain_mul;
        logic ndiv_go;
        logic fade_end;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        tick_mode_t mode;
        logic       gain_en;
        logic       div_done;
    } dp_status_t;

endpackage

// ===== src/lfc_ram.sv =====
// ============================================================================
// lfc_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ============================================================================
module lfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            store_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= store_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/lfc_div.sv =====
// ============================================================================
// lfc_div
// Restoring divider, one quotient bit per cycle. Shared by the gain step
// and the final blend division; the divisor is the fade length minus one.
// ============================================================================
module lfc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [lfc_pkg::DIV_W-1:0]     dividend,
    input  logic [lfc_pkg::FADE_W-1:0]    divisor,
    output logic                          done,
    output logic [lfc_pkg::DIV_W-1:0]     quotient
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [lfc_pkg::DCNT_W-1:0]    cnt_reg, cnt_next;
    logic [lfc_pkg::FADE_W-1:0]    rem_reg, rem_next;
    logic [lfc_pkg::DIV_W-1:0]     quo_reg, quo_next;
    logic [lfc_pkg::FADE_W-1:0]    dvs_reg, dvs_next;
    logic [lfc_pkg::FADE_W:0]      trial;
    logic [lfc_pkg::FADE_W:0]      diff;
    logic                          ge;

    // one shift-and-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[lfc_pkg::DIV_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    // iteration control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? diff[lfc_pkg::FADE_W-1:0] : trial[lfc_pkg::FADE_W-1:0];
            quo_next = {quo_reg[lfc_pkg::DIV_W-2:0], ge};
            cnt_next = cnt_reg + lfc_pkg::DCNT_W'(1);
            if (cnt_reg == lfc_pkg::DCNT_W'(lfc_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // operands and partial results
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (rem_reg < dvs_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule

// ===== src/lfc_dp.sv =====
// ============================================================================
// lfc_dp
// Datapath: configuration registers, slot bookkeeping, frame store, blend
// multipliers, shared divider, saturation and the output register.
// ============================================================================
module lfc_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  lfc_pkg::ctrl_cmd_t                   cmd,
    output lfc_pkg::dp_status_t                  status,
    input  logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                 frame_end,
    input  logic                                 cfg_valid,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lfc_pkg::LEN_W-1:0]            cfg_data,
    output logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                 frame_released,
    output logic                                 frame_dropped
);

    localparam int SB = lfc_pkg::SAMPLE_BITS;
    localparam int CW = lfc_pkg::CNT_W;
    localparam int FW = lfc_pkg::FADE_W;
    localparam int NW = lfc_pkg::NUM_W;
    localparam int DW = lfc_pkg::DIV_W;
    localparam int PW = lfc_pkg::GPROD_W;

    // configuration
    logic [lfc_pkg::LEN_W-1:0] fade_len_reg;
    logic                      gain_en_reg;

    // slot bookkeeping
    logic [CW-1:0] len_reg [2];
    logic [CW-1:0] len_next [2];
    logic [CW-1:0] pos_reg [2];
    logic [CW-1:0] pos_next [2];
    logic          ready_reg [2];
    logic          ready_next [2];
    logic          cur_reg, cur_next;
    logic [CW-1:0] load_cnt_reg, load_cnt_next;
    logic          disc_reg, disc_next;

    // item and blend operands
    logic [SB-1:0]        smp_reg;
    logic                 last_reg;
    logic [FW-1:0]        lm1_reg, k_reg;
    logic signed [NW-1:0] acc_reg, num_reg;
    logic [PW-1:0]        prod_reg;

    // result and output registers
    logic [SB-1:0] res_smp_reg, res_smp_next;
    logic          res_rel_reg, res_rel_next;
    logic          res_drop_reg, res_drop_next;
    logic [SB-1:0] out_smp_reg;
    logic          out_rel_reg, out_drop_reg;

    // slot views
    logic          nxt;
    logic          cur_ready, nxt_ready;
    logic [CW-1:0] cur_pos, nxt_pos, cur_len, nxt_len;

    // fade parameters
    logic [lfc_pkg::LEN_W-1:0]  len_clamped;
    logic [FW-1:0]              lm1_calc, k_calc;
    logic [lfc_pkg::KCMP_W-1:0] nxt_pos_w, lm1_w;

    // arithmetic
    logic [FW-1:0]              w_old, m_val;
    logic signed [NW-1:0]       rd_ext, w_old_ext, k_ext;
    logic signed [NW-1:0]       num_negated;
    logic                       num_neg;
    logic [lfc_pkg::MAG_W-1:0]  mag;
    logic [lfc_pkg::GAIN_W-1:0] gain;
    logic [PW:0]                gsum;
    logic [DW-1:0]              gnum, ndiv_val, div_dividend;
    logic [DW-1:0]              quo;
    logic                       div_done;
    logic [SB-1:0]              sat_val;

    // frame store ports
    logic                      ram_we, ram_re;
    logic [lfc_pkg::MEM_AW-1:0] ram_waddr, ram_raddr;
    logic [SB-1:0]              rd_data;

    // load decisions
    logic          disc_start, disc_eff, tgt, room;
    logic [CW-1:0] cnt_after;

    function automatic logic [CW-1:0] advance(input logic [CW-1:0] pos,
                                              input logic [CW-1:0] len);
        logic [CW-1:0] p;
        p = pos + CW'(1);
        return (p >= len) ? '0 : p;
    endfunction

    // current and next slot views
    always_comb
    begin
        nxt       = ~cur_reg;
        cur_ready = cur_reg ? ready_reg[1] : ready_reg[0];
        nxt_ready = cur_reg ? ready_reg[0] : ready_reg[1];
        cur_pos   = cur_reg ? pos_reg[1] : pos_reg[0];
        nxt_pos   = cur_reg ? pos_reg[0] : pos_reg[1];
        cur_len   = cur_reg ? len_reg[1] : len_reg[0];
        nxt_len   = cur_reg ? len_reg[0] : len_reg[1];
    end

    // tick mode for the controller
    always_comb
    begin
        status.gain_en  = gain_en_reg;
        status.div_done = div_done;
        if (cur_ready && !nxt_ready)
        begin
            status.mode = lfc_pkg::MODE_PLAY;
        end
        else if (cur_ready && nxt_ready)
        begin
            status.mode = lfc_pkg::MODE_FADE;
        end
        else
        begin
            status.mode = lfc_pkg::MODE_NONE;
        end
    end

    // clamp fade length, fade index limited to L-1
    always_comb
    begin
        if (fade_len_reg < lfc_pkg::LEN_W'(lfc_pkg::FADE_MIN))
        begin
            len_clamped = lfc_pkg::LEN_W'(lfc_pkg::FADE_MIN);
        end
        else if (fade_len_reg > lfc_pkg::LEN_W'(lfc_pkg::FADE_MAX))
        begin
            len_clamped = lfc_pkg::LEN_W'(lfc_pkg::FADE_MAX);
        end
        else
        begin
            len_clamped = fade_len_reg;
        end
        lm1_calc  = FW'(len_clamped - lfc_pkg::LEN_W'(1));
        nxt_pos_w = lfc_pkg::KCMP_W'(nxt_pos);
        lm1_w     = lfc_pkg::KCMP_W'(lm1_calc);
        k_calc    = (nxt_pos_w > lm1_w) ? lm1_calc : FW'(nxt_pos_w);
    end

    // load target and discard decision
    always_comb
    begin
        disc_start = (load_cnt_reg == '0) && !disc_reg && ready_reg[0] && ready_reg[1];
        disc_eff   = disc_reg || disc_start;
        tgt        = cur_ready ? nxt : cur_reg;
        room       = (load_cnt_reg < CW'(lfc_pkg::FRAME_DEPTH));
        cnt_after  = room ? (load_cnt_reg + CW'(1)) : load_cnt_reg;
    end

    // frame store access
    always_comb
    begin
        ram_we    = cmd.load_step && !disc_eff && room;
        ram_waddr = {tgt, load_cnt_reg[lfc_pkg::ADDR_W-1:0]};
        ram_re    = cmd.tick_setup || cmd.fade_old;
        ram_raddr = cmd.fade_old ? {nxt, nxt_pos[lfc_pkg::ADDR_W-1:0]}
                                 : {cur_reg, cur_pos[lfc_pkg::ADDR_W-1:0]};
    end

    lfc_ram #(
        .WIDTH (SB),
        .DEPTH (lfc_pkg::MEM_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (smp_reg),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (rd_data)
    );

    // blend operands and magnitude
    always_comb
    begin
        w_old       = lm1_reg - k_reg;
        m_val       = (k_reg < w_old) ? k_reg : w_old;
        rd_ext      = NW'($signed(rd_data));
        w_old_ext   = NW'({1'b0, w_old});
        k_ext       = NW'({1'b0, k_reg});
        num_neg     = num_reg[NW-1];
        num_negated = -num_reg;
        mag         = num_neg ? num_negated[lfc_pkg::MAG_W-1:0]
                              : num_reg[lfc_pkg::MAG_W-1:0];
        gain        = lfc_pkg::GAIN_W'(lfc_pkg::GAIN_ONE) + quo[lfc_pkg::GAIN_W-1:0];
    end

    // divider operands: gain ratio first, then the rounded blend
    always_comb
    begin
        gnum = DW'(lfc_pkg::GAIN_SPAN) * DW'(m_val) + DW'(lm1_reg >> 1);
        gsum = (PW + 1)'(prod_reg) + ((PW + 1)'(lm1_reg) << (lfc_pkg::GAIN_FRAC - 1));
        if (gain_en_reg)
        begin
            ndiv_val = DW'(gsum >> lfc_pkg::GAIN_FRAC);
        end
        else
        begin
            ndiv_val = DW'(mag) + DW'(lm1_reg >> 1);
        end
        div_dividend = cmd.gdiv_go ? gnum : ndiv_val;
    end

    lfc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.gdiv_go || cmd.ndiv_go),
        .dividend (div_dividend),
        .divisor  (lm1_reg),
        .done     (div_done),
        .quotient (quo)
    );

    // signed saturation of the rounded quotient
    always_comb
    begin
        if (!num_neg)
        begin
            sat_val = (quo > DW'(lfc_pkg::SAT_MAX)) ? SB'(lfc_pkg::SAT_MAX) : SB'(quo);
        end
        else if (quo > DW'(lfc_pkg::SAT_MAX + 1))
        begin
            sat_val = SB'(lfc_pkg::SAT_MAX + 1);
        end
        else
        begin
            sat_val = SB'(DW'(0) - quo);
        end
    end

    // slot state and result updates
    always_comb
    begin
        len_next      = len_reg;
        pos_next      = pos_reg;
        ready_next    = ready_reg;
        cur_next      = cur_reg;
        load_cnt_next = load_cnt_reg;
        disc_next     = disc_reg;
        res_smp_next  = res_smp_reg;
        res_rel_next  = res_rel_reg;
        res_drop_next = res_drop_reg;

        if (cmd.accept)
        begin
            res_smp_next  = '0;
            res_rel_next  = 1'b0;
            res_drop_next = 1'b0;
        end

        if (cmd.load_step)
        begin
            if (disc_eff)
            begin
                if (last_reg)
                begin
                    res_drop_next = 1'b1;
                    disc_next     = 1'b0;
                    load_cnt_next = '0;
                end
                else
                begin
                    disc_next = 1'b1;
                end
            end
            else
            begin
                load_cnt_next = cnt_after;
                if (last_reg)
                begin
                    len_next[tgt]   = cnt_after;
                    pos_next[tgt]   = '0;
                    ready_next[tgt] = 1'b1;
                    load_cnt_next   = '0;
                end
            end
        end

        if (cmd.play_cap)
        begin
            res_smp_next      = rd_data;
            pos_next[cur_reg] = advance(cur_pos, cur_len);
        end

        if (cmd.fade_end)
        begin
            res_smp_next      = sat_val;
            pos_next[cur_reg] = advance(cur_pos, cur_len);
            pos_next[nxt]     = advance(nxt_pos, nxt_len);
            if (k_reg == lm1_reg)
            begin
                ready_next[cur_reg] = 1'b0;
                pos_next[cur_reg]   = '0;
                cur_next            = nxt;
                res_rel_next        = 1'b1;
            end
        end
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_len_reg  <= lfc_pkg::LEN_W'(lfc_pkg::LEN_RESET);
            gain_en_reg   <= 1'b0;
            len_reg[0]    <= '0;
            len_reg[1]    <= '0;
            pos_reg[0]    <= '0;
            pos_reg[1]    <= '0;
            ready_reg[0]  <= 1'b0;
            ready_reg[1]  <= 1'b0;
            cur_reg       <= 1'b0;
            load_cnt_reg  <= '0;
            disc_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    lfc_pkg::CFG_FADE_LEN: fade_len_reg <= cfg_data;
                    lfc_pkg::CFG_GAIN_EN:  gain_en_reg  <= cfg_data[0];
                endcase
            end
            len_reg      <= len_next;
            pos_reg      <= pos_next;
            ready_reg    <= ready_next;
            cur_reg      <= cur_next;
            load_cnt_reg <= load_cnt_next;
            disc_reg     <= disc_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            smp_reg  <= sample_in;
            last_reg <= frame_end;
        end
        if (cmd.tick_setup)
        begin
            lm1_reg <= lm1_calc;
            k_reg   <= k_calc;
        end
        if (cmd.fade_old)
        begin
            acc_reg <= rd_ext * w_old_ext;
        end
        if (cmd.fade_new)
        begin
            num_reg <= acc_reg + rd_ext * k_ext;
        end
        if (cmd.gain_mul)
        begin
            prod_reg <= PW'(mag) * PW'(gain);
        end
        res_smp_reg  <= res_smp_next;
        res_rel_reg  <= res_rel_next;
        res_drop_reg <= res_drop_next;
        if (cmd.out_load)
        begin
            out_smp_reg  <= res_smp_reg;
            out_rel_reg  <= res_rel_reg;
            out_drop_reg <= res_drop_reg;
        end
    end

    assign sample_out     = $signed(out_smp_reg);
    assign frame_released = out_rel_reg;
    assign frame_dropped  = out_drop_reg;

`ifndef SYNTHESIS
    a_discard_at_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        disc_reg |-> (load_cnt_reg == '0))
        else $error("discarding with a partial frame count");

    a_ready_slot_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg[0] |-> (len_reg[0] != '0)) and (ready_reg[1] |-> (len_reg[1] != '0)))
        else $error("ready slot with zero length");

    a_position_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        (ready_reg[0] |-> (pos_reg[0] < len_reg[0]))
        and (ready_reg[1] |-> (pos_reg[1] < len_reg[1])))
        else $error("play position beyond frame length");
`endif

endmodule

// ===== src/lfc_ctrl.sv =====
// ============================================================================
// lfc_ctrl
// Controller: accepts items, sequences loads, plain ticks and crossfade
// ticks through the datapath, and owns the output valid.
// ============================================================================
module lfc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                operation,
    output logic                out_valid,
    input  logic                out_ready,
    output lfc_pkg::ctrl_cmd_t  cmd,
    input  lfc_pkg::dp_status_t status
);

    lfc_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || out_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lfc_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (operation == lfc_pkg::OP_TICK) ? lfc_pkg::S_TICK
                                                                 : lfc_pkg::S_LOAD;
                end
            end
            lfc_pkg::S_LOAD:      state_next = lfc_pkg::S_FINISH;
            lfc_pkg::S_TICK:
            begin
                unique case (status.mode)
                    lfc_pkg::MODE_PLAY: state_next = lfc_pkg::S_PLAY;
                    lfc_pkg::MODE_FADE: state_next = lfc_pkg::S_FADE_OLD;
                    default:            state_next = lfc_pkg::S_FINISH;
                endcase
            end
            lfc_pkg::S_PLAY:      state_next = lfc_pkg::S_FINISH;
            lfc_pkg::S_FADE_OLD:  state_next = lfc_pkg::S_FADE_NEW;
            lfc_pkg::S_FADE_NEW:
            begin
                state_next = status.gain_en ? lfc_pkg::S_GDIV_GO : lfc_pkg::S_NDIV_GO;
            end
            lfc_pkg::S_GDIV_GO:   state_next = lfc_pkg::S_GDIV_WAIT;
            lfc_pkg::S_GDIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = lfc_pkg::S_GAIN_MUL;
                end
            end
            lfc_pkg::S_GAIN_MUL:  state_next = lfc_pkg::S_NDIV_GO;
            lfc_pkg::S_NDIV_GO:   state_next = lfc_pkg::S_NDIV_WAIT;
            lfc_pkg::S_NDIV_WAIT:
            begin
                if (status.div_done)
                begin
                    state_next = lfc_pkg::S_FADE_END;
                end
            end
            lfc_pkg::S_FADE_END:  state_next = lfc_pkg::S_FINISH;
            lfc_pkg::S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = lfc_pkg::S_IDLE;
                end
            end
            default:              state_next = lfc_pkg::S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            lfc_pkg::S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            lfc_pkg::S_LOAD:      cmd.load_step  = 1'b1;
            lfc_pkg::S_TICK:      cmd.tick_setup = 1'b1;
            lfc_pkg::S_PLAY:      cmd.play_cap   = 1'b1;
            lfc_pkg::S_FADE_OLD:  cmd.fade_old   = 1'b1;
            lfc_pkg::S_FADE_NEW:  cmd.fade_new   = 1'b1;
            lfc_pkg::S_GDIV_GO:   cmd.gdiv_go    = 1'b1;
            lfc_pkg::S_GDIV_WAIT: cmd            = '0;
            lfc_pkg::S_GAIN_MUL:  cmd.gain_mul   = 1'b1;
            lfc_pkg::S_NDIV_GO:   cmd.ndiv_go    = 1'b1;
            lfc_pkg::S_NDIV_WAIT: cmd            = '0;
            lfc_pkg::S_FADE_END:  cmd.fade_end   = 1'b1;
            lfc_pkg::S_FINISH:    cmd.out_load   = out_free;
            default:              cmd            = '0;
        endcase
    end

    // output beat valid
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lfc_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_starts_work: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == lfc_pkg::S_LOAD
                                    || state_reg == lfc_pkg::S_TICK))
        else $error("accepted beat did not start a load or tick");
`endif

endmodule

// ===== src/looped_frame_crossfader_core.sv =====
// ============================================================================
// looped_frame_crossfader_core
// Two-slot looping frame player with linear crossfade and optional makeup
// gain between an outgoing and an incoming frame.
// ============================================================================
// Each input beat is a load (operation 0: one frame sample, frame_end closes
// the frame) or a tick (operation 1: one output sample), and every beat gives
// exactly one output beat. One beat is in work at a time; the next is taken
// while the previous result still waits in the output register. A load is
// handled in the load state, a plain tick reads the frame store and then
// captures the sample, and a crossfade tick reads both frames and then runs the
// shared bit-serial divider, which makes one quotient bit per cycle over 27
// bits, once per fade step and twice with gain. After each beat the controller
// returns to idle before the next beat is taken. Frame samples live in one
// 2048-entry RAM (two 1024-sample slots) read through its single read port.
// The configuration port is always ready; write it only while idle.
module looped_frame_crossfader_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  operation,
    input  logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic                                  frame_end,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [lfc_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic                                  frame_released,
    output logic                                  frame_dropped,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [lfc_pkg::LEN_W-1:0]             cfg_data
);

    lfc_pkg::ctrl_cmd_t  cmd;
    lfc_pkg::dp_status_t status;

    // register writes are always accepted
    assign cfg_ready = 1'b1;

    // sequencing
    lfc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    // storage and arithmetic
    lfc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample_in      (sample_in),
        .frame_end      (frame_end),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .sample_out     (sample_out),
        .frame_released (frame_released),
        .frame_dropped  (frame_dropped)
    );

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tb_top
// Self-checking bench for the looped frame crossfader core. Frames are loaded
// sample by sample and played by ticks. Each output beat is checked against a
// bit-accurate software copy of the player: looping, linear crossfade,
// makeup gain, saturation, frame drop and release. The bench runs a short
// directed part, then random traffic under changing fade settings.
// ============================================================================
module tb_top;

    localparam int SB            = lfc_pkg::SAMPLE_BITS;
    localparam int DEPTH         = lfc_pkg::FRAME_DEPTH;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_BEATS  = 200;
    localparam int PHASE_COUNT   = 12;
    localparam int DRAIN_CYCLES  = 80;

    typedef struct packed {
        logic signed [SB-1:0] sample;
        logic                 released;
        logic                 dropped;
    } beat_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_ready;
    logic                               operation = lfc_pkg::OP_LOAD;
    logic signed [SB-1:0]               sample_in = '0;
    logic                               frame_end = 1'b0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    logic signed [SB-1:0]               sample_out;
    logic                               frame_released;
    logic                               frame_dropped;
    logic                               cfg_valid = 1'b0;
    logic                               cfg_ready;
    logic [lfc_pkg::CFG_IDX_W-1:0]      cfg_index = lfc_pkg::CFG_FADE_LEN;
    logic [lfc_pkg::LEN_W-1:0]          cfg_data = '0;

    // player copy: frame store, slot state, loader state, settings
    logic signed [SB-1:0] frame_mem [0:2*DEPTH-1];
    int unsigned          slot_len [2] = '{0, 0};
    int unsigned          slot_pos [2] = '{0, 0};
    bit                   slot_full [2] = '{1'b0, 1'b0};
    int                   cur_slot = 0;
    int unsigned          fill_count = 0;
    bit                   fill_discard = 1'b0;
    int unsigned          fade_len = lfc_pkg::LEN_RESET;
    bit                   gain_on = 1'b0;

    beat_t expected_beats [$];
    int    idle_pct = 24;
    int    failures = 0;
    int    beats_sent = 0;
    int    beats_checked = 0;
    int    fades_done = 0;
    int    frames_dropped = 0;

    looped_frame_crossfader_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .operation      (operation),
        .sample_in      (sample_in),
        .frame_end      (frame_end),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .sample_out     (sample_out),
        .frame_released (frame_released),
        .frame_dropped  (frame_dropped),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #6 clk = ~clk;

    // loop position wraps at the frame length
    function automatic void step_position(input int s);
        int unsigned p;
        p = slot_pos[s] + 1;
        if (p >= slot_len[s])
            p = 0;
        slot_pos[s] = p;
    endfunction

    // apply one accepted input beat to the player copy, return its output beat
    function automatic beat_t advance_player(input logic op,
                                             input logic signed [SB-1:0] smp,
                                             input logic fe);
        beat_t  beat;
        int     c;
        int     n;
        int     tgt;
        longint lm1;
        longint k;
        longint m;
        longint g;
        longint num;
        longint den;
        longint mag;
        longint q;
        longint val;
        beat = '0;
        c = cur_slot;
        n = 1 - cur_slot;
        if (op == lfc_pkg::OP_LOAD)
        begin
            // a frame starting while both slots hold frames is thrown away
            if (fill_count == 0 && !fill_discard && slot_full[0] && slot_full[1])
                fill_discard = 1'b1;
            if (fill_discard)
            begin
                if (fe)
                begin
                    beat.dropped = 1'b1;
                    fill_discard = 1'b0;
                    fill_count = 0;
                end
            end
            else
            begin
                tgt = slot_full[c] ? n : c;
                if (fill_count < DEPTH)
                begin
                    frame_mem[tgt*DEPTH + fill_count] = smp;
                    fill_count++;
                end
                if (fe)
                begin
                    slot_len[tgt] = fill_count;
                    slot_pos[tgt] = 0;
                    slot_full[tgt] = 1'b1;
                    fill_count = 0;
                end
            end
        end
        else if (slot_full[c] && !slot_full[n])
        begin
            beat.sample = frame_mem[c*DEPTH + slot_pos[c]];
            step_position(c);
        end
        else if (slot_full[c] && slot_full[n])
        begin
            // fade length clamped to its legal range
            if (fade_len < lfc_pkg::FADE_MIN)
                lm1 = lfc_pkg::FADE_MIN - 1;
            else if (fade_len > lfc_pkg::FADE_MAX)
                lm1 = lfc_pkg::FADE_MAX - 1;
            else
                lm1 = fade_len - 1;
            k = slot_pos[n];
            if (k > lm1)
                k = lm1;
            num = longint'(frame_mem[c*DEPTH + slot_pos[c]]) * (lm1 - k)
                + longint'(frame_mem[n*DEPTH + slot_pos[n]]) * k;
            den = lm1;
            if (gain_on)
            begin
                m = (k < lm1 - k) ? k : lm1 - k;
                g = lfc_pkg::GAIN_ONE + (lfc_pkg::GAIN_SPAN * m + lm1 / 2) / lm1;
                num = num * g;
                den = lm1 * lfc_pkg::GAIN_ONE;
            end
            // round half away from zero, then saturate
            mag = (num < 0) ? -num : num;
            q = (mag + den / 2) / den;
            val = (num < 0) ? -q : q;
            if (val > lfc_pkg::SAT_MAX)
                val = lfc_pkg::SAT_MAX;
            else if (val < -lfc_pkg::SAT_MAX - 1)
                val = -lfc_pkg::SAT_MAX - 1;
            beat.sample = val[SB-1:0];
            step_position(c);
            step_position(n);
            if (k >= lm1)
            begin
                slot_full[c] = 1'b0;
                slot_pos[c] = 0;
                cur_slot = n;
                beat.released = 1'b1;
            end
        end
        return beat;
    endfunction

    function automatic logic signed [SB-1:0] random_sample();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    // send one input beat, with a random gap before it
    task automatic send_beat(input logic op, input logic signed [SB-1:0] smp,
                             input logic fe);
        beat_t want;
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        in_valid  <= 1'b1;
        operation <= op;
        sample_in <= smp;
        frame_end <= fe;
        do
            @(posedge clk);
        while (!in_ready);
        want = advance_player(op, smp, fe);
        if (want.released)
            fades_done++;
        if (want.dropped)
            frames_dropped++;
        expected_beats.push_back(want);
        beats_sent++;
    endtask

    // tick payload is ignored by the block, so it carries random bits
    task automatic send_tick();
        send_beat(lfc_pkg::OP_TICK, 16'($urandom), 1'($urandom));
    endtask

    task automatic tick_burst(input int n);
        for (int i = 0; i < n; i++)
            send_tick();
    endtask

    // one frame of random samples, ticks sprinkled in while it loads
    task automatic load_frame(input int n);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 20)
                send_tick();
            send_beat(lfc_pkg::OP_LOAD, random_sample(), i == n - 1);
        end
    endtask

    // wait for the block to go idle
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // write fade length then gain enable, back to back, while idle
    task automatic program_fade(input int unsigned len, input bit gain);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= lfc_pkg::CFG_FADE_LEN;
        cfg_data  <= len[lfc_pkg::LEN_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        fade_len = len & ((1 << lfc_pkg::LEN_W) - 1);
        cfg_index <= lfc_pkg::CFG_GAIN_EN;
        cfg_data  <= {10'($urandom), gain};
        do
            @(posedge clk);
        while (!cfg_ready);
        gain_on = gain;
        cfg_valid <= 1'b0;
    endtask

    // tick with no frame loaded gives zero
    task automatic test_empty_tick();
        send_beat(lfc_pkg::OP_TICK, 16'sh1234, 1'b1);
    endtask

    // loop playback, frame drop while both slots full, full fade with gain
    task automatic test_loop_and_fade();
        program_fade(4, 1'b1);
        send_beat(lfc_pkg::OP_LOAD, 16'sh7fff, 1'b0);
        send_beat(lfc_pkg::OP_LOAD, 16'sh8000, 1'b1);
        tick_burst(3);
        send_beat(lfc_pkg::OP_LOAD, 16'sh7fff, 1'b0);
        send_beat(lfc_pkg::OP_LOAD, 16'sh7fff, 1'b0);
        send_beat(lfc_pkg::OP_LOAD, 16'sh7fff, 1'b1);
        send_beat(lfc_pkg::OP_LOAD, 16'sh0000, 1'b0);
        send_beat(lfc_pkg::OP_LOAD, 16'sh5555, 1'b1);
        tick_burst(4);
    endtask

    // fade index past a shortened fade length ends the fade at once
    task automatic test_fade_cut();
        program_fade(1024, 1'b1);
        for (int i = 0; i < 4; i++)
            send_beat(lfc_pkg::OP_LOAD, 16'sh8000, i == 3);
        tick_burst(3);
        program_fade(2, 1'b0);
        send_tick();
    endtask

    // samples past the frame depth are ignored
    task automatic test_overlong_frame();
        for (int i = 0; i < DEPTH + 3; i++)
            send_beat(lfc_pkg::OP_LOAD, random_sample(), i == DEPTH + 2);
        tick_burst(3);
    endtask

    // random frames and tick bursts under a series of fade settings
    task automatic test_random_traffic();
        int unsigned lens [PHASE_COUNT];
        bit          gains [PHASE_COUNT];
        int          goal;
        int          burst_max;
        int          pick;
        lens  = '{5, 2, 33, 1024, 12, 0, 2047, 64, 1, 9, 300, 3};
        gains = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            program_fade(lens[ph], gains[ph]);
            // one phase runs with no gaps on either side
            idle_pct = (ph == 4) ? 0 : 24;
            burst_max = (fade_len > 48 || fade_len == 0) ? 56 : fade_len + 8;
            goal = beats_sent + RANDOM_BEATS / PHASE_COUNT;
            while (beats_sent < goal)
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    load_frame(($urandom_range(9) == 0) ? $urandom_range(25, 200)
                                                        : $urandom_range(1, 24));
                else if (pick < 85)
                    tick_burst($urandom_range(1, burst_max));
                else
                    send_beat(1'($urandom), 16'($urandom), 1'($urandom));
            end
        end
        idle_pct = 24;
    endtask

    // output side: random backpressure and beat checking
    always @(posedge clk)
    begin : check_outputs
        beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
            begin
                $error("output beat with no input beat pending: sample_out %0d", sample_out);
                failures++;
            end
            else
            begin
                want = expected_beats.pop_front();
                beats_checked++;
                if (sample_out !== want.sample)
                begin
                    $error("sample_out: expected %0d, actual %0d", want.sample, sample_out);
                    failures++;
                end
                if (frame_released !== want.released)
                begin
                    $error("frame_released: expected %0b, actual %0b", want.released,
                           frame_released);
                    failures++;
                end
                if (frame_dropped !== want.dropped)
                begin
                    $error("frame_dropped: expected %0b, actual %0b", want.dropped,
                           frame_dropped);
                    failures++;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= idle_pct);
    end

    // watchdog on cycles with no beat moving on any channel
    initial
    begin : watchdog
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                stall = 0;
            else
                stall++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_tick();
        test_loop_and_fade();
        test_fade_cut();
        test_overlong_frame();
        test_random_traffic();
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d input beats, %0d output beats checked", beats_sent, beats_checked);
        $display("fades completed: %0d, frames dropped: %0d", fades_done, frames_dropped);
        if (failures == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== looped_frame_crossfader_core.f =====
src/lfc_pkg.sv
src/lfc_ram.sv
src/lfc_div.sv
src/lfc_dp.sv
src/lfc_ctrl.sv
src/looped_frame_crossfader_core.sv
bench/tb_top.sv
